FILE: rtl/led_fade_command_sequencer_core_defines.svh
// Assertion macros used by the back part of the LED fade command sequencer.
`ifndef LED_FADE_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define LED_FADE_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LFCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfcs assertion failed");
`define LFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfcs assertion failed");
`else
`define LFCS_ASSERT_NOW(label, clk, rst, ante, cons)
`define LFCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/lfcs_pkg.sv
// Types, constants and the gamma table of the LED fade command sequencer.
package lfcs_pkg;
  localparam int NUM_LEDS    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int PWM_BITS    = 12;
  localparam int LOG_FRAC    = 28;
  localparam int US_PER_MS   = 1000;
  localparam int LEVEL_MAX   = 255;
  localparam int DUR_W       = 26;
  localparam int TOT_W       = 36;
  localparam int LED_W       = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_IDLE   = 2'd0,
    OP_FADE   = 2'd1,
    OP_DELAY  = 2'd2,
    OP_SIGNAL = 2'd3
  } op_t;

  localparam logic [1:0] FUNC_FADE   = 2'd0;
  localparam logic [1:0] FUNC_DELAY  = 2'd1;
  localparam logic [1:0] FUNC_SIGNAL = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  typedef struct packed {
    logic             is_tick;
    op_t              op;
    logic [2:0]       led;
    logic [7:0]       level;
    logic [DUR_W-1:0] dur;
    logic [31:0]      now;
  } item_t;

  typedef logic [PWM_BITS-1:0] gamma_t [256];

  // Base-2 logarithm in Q28, fraction bits found by repeated squaring.
  function automatic logic [63:0] fix_log2(logic [31:0] x_in);
    logic [31:0] x;
    int          k;
    logic [63:0] m;
    logic [63:0] r;
    x = (x_in == 32'd0) ? 32'd1 : x_in;
    k = 0;
    for (int i = 0; i < 31; i++) begin
      if ((x >> (i + 1)) != 32'd0) k = i + 1;
    end
    m = (64'(x) << LOG_FRAC) >> k;
    r = 64'(k) << LOG_FRAC;
    for (int b = 1; b <= LOG_FRAC; b++) begin
      m = (m * m) >> LOG_FRAC;
      if (m >= (64'd2 << LOG_FRAC)) begin
        m = m >> 1;
        r = r | (64'd1 << (LOG_FRAC - b));
      end
    end
    return r;
  endfunction

  function automatic gamma_t build_gamma();
    gamma_t      g;
    logic [63:0] ltop;
    logic [63:0] rhs;
    logic [31:0] top;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    top  = (32'd1 << PWM_BITS) - 32'd1;
    ltop = fix_log2(top);
    for (int i = 0; i < 256; i++) begin
      rhs = 64'(i) * ltop + (64'd255 << LOG_FRAC);
      lo  = 32'd0;
      hi  = top - 32'd1;
      for (int n = 0; n < 20; n++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo + 32'd1) >> 1);
          if (64'd255 * fix_log2(32'd2 * mid + 32'd1) <= rhs) lo = mid;
          else hi = mid - 32'd1;
        end
      end
      g[i] = lo[PWM_BITS-1:0];
    end
    return g;
  endfunction

  localparam gamma_t GAMMA = build_gamma();
endpackage

FILE: rtl/lfcs_if.sv
// Valid/ready channel interfaces for requests and results.
interface lfcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  led_index;
  logic [7:0]  target_level;
  logic [15:0] duration;
  logic [31:0] now_us;
  modport source (output valid, func, led_index, target_level, duration, now_us,
                  input ready);
  modport sink (input valid, func, led_index, target_level, duration, now_us,
                output ready);
endinterface

interface lfcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_led;
  logic        write_valid;
  logic [11:0] pwm_level;
  logic        signal_fired;
  logic        queue_idle;
  logic        last_result;
  modport source (output valid, out_led, write_valid, pwm_level, signal_fired, queue_idle,
                  last_result, input ready);
  modport sink (input valid, out_led, write_valid, pwm_level, signal_fired, queue_idle,
                last_result, output ready);
endinterface

FILE: rtl/lfcs_front.sv
// Front part: accepts requests, classifies them and buffers them in a two-entry queue.
module lfcs_front (
  input  logic              clk,
  input  logic              rst,
  lfcs_in_if.sink           cmd,
  output logic              item_valid,
  input  logic              item_ready,
  output lfcs_pkg::item_t   item
);
  lfcs_pkg::item_t    buf_q [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  lfcs_pkg::item_t    incoming;
  logic               push;
  logic               pop;

  always_comb begin
    incoming.is_tick = (cmd.func == lfcs_pkg::FUNC_TICK);
    unique case (cmd.func)
      lfcs_pkg::FUNC_FADE:   incoming.op = lfcs_pkg::OP_FADE;
      lfcs_pkg::FUNC_DELAY:  incoming.op = lfcs_pkg::OP_DELAY;
      lfcs_pkg::FUNC_SIGNAL: incoming.op = lfcs_pkg::OP_SIGNAL;
      default:               incoming.op = lfcs_pkg::OP_IDLE;
    endcase
    incoming.led   = cmd.led_index;
    incoming.level = (cmd.func == lfcs_pkg::FUNC_FADE) ? cmd.target_level : 8'd0;
    // Durations are kept in microseconds; a signal has none.
    incoming.dur   = (cmd.func == lfcs_pkg::FUNC_SIGNAL) ? '0 :
                     lfcs_pkg::DUR_W'({10'd0, cmd.duration} *
                                      26'(lfcs_pkg::US_PER_MS));
    incoming.now   = cmd.now_us;
  end

  assign cmd.ready  = (count != 2'd2);
  assign push       = cmd.valid && cmd.ready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_valid && item_ready;
  assign item       = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        buf_q[wr_ptr] <= incoming;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: rtl/lfcs_div.sv
// Restoring divider that yields an eight-bit quotient, one bit per cycle.
module lfcs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lfcs_pkg::TOT_W-2:0]   dividend,
  input  logic [lfcs_pkg::DUR_W-1:0]   divisor,
  output logic                         busy,
  output logic                         done,
  output logic [7:0]                   quot
);
  logic [lfcs_pkg::TOT_W-2:0] rem;
  logic [lfcs_pkg::TOT_W-2:0] dsh;
  logic [2:0]                 cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        dsh  <= (lfcs_pkg::TOT_W-1)'(divisor) << 7;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= {quot[6:0], 1'b1};
        end else begin
          quot <= {quot[6:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/lfcs_back.sv
// Back part: holds the per-LED command queues and walks the LEDs on each tick.
`include "led_fade_command_sequencer_core_defines.svh"
module lfcs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  lfcs_pkg::item_t  item,
  lfcs_out_if.source       res
);
  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_MULA, S_MULB, S_SUM, S_DIV, S_FIN, S_EMIT
  } state_t;

  state_t                       state;
  lfcs_pkg::op_t                q_op  [lfcs_pkg::NUM_LEDS][lfcs_pkg::QUEUE_DEPTH];
  logic [7:0]                   q_lvl [lfcs_pkg::NUM_LEDS][lfcs_pkg::QUEUE_DEPTH];
  logic [lfcs_pkg::DUR_W-1:0]   q_dur [lfcs_pkg::NUM_LEDS][lfcs_pkg::QUEUE_DEPTH];
  logic                         active [lfcs_pkg::NUM_LEDS];
  logic [31:0]                  start_time [lfcs_pkg::NUM_LEDS];
  logic [7:0]                   last_level [lfcs_pkg::NUM_LEDS];

  logic [lfcs_pkg::LED_W-1:0]   led;
  logic [31:0]                  now;
  logic [31:0]                  el;
  logic [33:0]                  prod_a;
  logic signed [35:0]           prod_b;
  logic                         res_wv;
  logic                         res_sig;
  logic [11:0]                  res_pwm;
  logic                         div_start;
  logic                         div_busy;
  logic                         div_done;
  logic [7:0]                   div_q;
  logic [lfcs_pkg::TOT_W-2:0]   div_num;

  lfcs_pkg::op_t                hd_op;
  logic [7:0]                   hd_lvl;
  logic [lfcs_pkg::DUR_W-1:0]   hd_dur;
  logic [31:0]                  el_now;
  logic                         expired;
  logic [lfcs_pkg::SLOT_W-1:0]  pick;
  logic [lfcs_pkg::LED_W-1:0]   enq_led;
  logic                         enq_ok;
  logic signed [8:0]            diff;
  logic signed [lfcs_pkg::TOT_W-1:0] tot;
  logic                         emit_go;
  logic                         at_last;
  logic [lfcs_pkg::PWM_BITS-1:0] g_fin;
  logic [lfcs_pkg::PWM_BITS-1:0] g_div;

  assign hd_op   = q_op[led][0];
  assign hd_lvl  = q_lvl[led][0];
  assign hd_dur  = q_dur[led][0];
  assign el_now  = now - start_time[led];
  assign expired = (el_now >= 32'(hd_dur));
  assign diff    = $signed({1'b0, hd_lvl}) - $signed({1'b0, last_level[led]});
  assign tot     = $signed({2'b00, prod_a}) + prod_b;
  assign emit_go = !res.valid || res.ready;
  assign at_last = (32'(led) == lfcs_pkg::NUM_LEDS - 1);
  assign enq_led = lfcs_pkg::LED_W'(item.led);
  assign enq_ok  = (32'(item.led) < lfcs_pkg::NUM_LEDS);
  assign item_ready = (state == S_IDLE);
  assign g_fin   = lfcs_pkg::GAMMA[hd_lvl];
  assign g_div   = lfcs_pkg::GAMMA[div_q];

  // First idle slot of the addressed queue; a full queue reuses the last slot.
  always_comb begin
    pick = lfcs_pkg::SLOT_W'(lfcs_pkg::QUEUE_DEPTH - 1);
    for (int s = lfcs_pkg::QUEUE_DEPTH - 1; s >= 0; s--) begin
      if (q_op[enq_led][s] == lfcs_pkg::OP_IDLE) pick = lfcs_pkg::SLOT_W'(s);
    end
  end

  lfcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (hd_dur),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
      div_start <= 1'b0;
      led       <= '0;
      for (int l = 0; l < lfcs_pkg::NUM_LEDS; l++) begin
        active[l]     <= 1'b0;
        start_time[l] <= 32'd0;
        last_level[l] <= 8'd0;
        for (int s = 0; s < lfcs_pkg::QUEUE_DEPTH; s++) q_op[l][s] <= lfcs_pkg::OP_IDLE;
      end
    end else begin
      // The divider is kicked off once the interpolation sum is ready.
      div_start <= (state == S_SUM);
      // A taken result clears, unless the emit state loads the next one.
      if (res.valid && res.ready && state != S_EMIT) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.is_tick) begin
              now   <= item.now;
              led   <= '0;
              state <= S_EVAL;
            end else if (enq_ok) begin
              q_op[enq_led][pick]  <= item.op;
              q_lvl[enq_led][pick] <= item.level;
              q_dur[enq_led][pick] <= item.dur;
            end
          end
        end
        S_EVAL: begin
          el      <= el_now;
          res_wv  <= 1'b0;
          res_sig <= 1'b0;
          res_pwm <= 12'd0;
          if (!active[led]) begin
            if (hd_op != lfcs_pkg::OP_IDLE) begin
              active[led]     <= 1'b1;
              start_time[led] <= now;
            end
            state <= S_EMIT;
          end else begin
            unique case (hd_op)
              lfcs_pkg::OP_FADE:   state <= expired ? S_FIN : S_MULA;
              lfcs_pkg::OP_DELAY:  state <= expired ? S_FIN : S_EMIT;
              lfcs_pkg::OP_SIGNAL: begin
                res_sig <= 1'b1;
                state   <= S_FIN;
              end
              default:             state <= S_EMIT;
            endcase
          end
        end
        S_MULA: begin
          prod_a <= 34'(last_level[led]) * 34'(hd_dur);
          state  <= S_MULB;
        end
        S_MULB: begin
          prod_b <= $signed({1'b0, el[lfcs_pkg::DUR_W-1:0]}) * diff;
          state  <= S_SUM;
        end
        S_SUM: begin
          div_num   <= tot[lfcs_pkg::TOT_W-1] ? '0 : tot[lfcs_pkg::TOT_W-2:0];
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_wv  <= 1'b1;
            res_pwm <= 12'(g_div);
            state   <= S_EMIT;
          end
        end
        S_FIN: begin
          if (hd_op == lfcs_pkg::OP_FADE) begin
            res_wv          <= 1'b1;
            res_pwm         <= 12'(g_fin);
            last_level[led] <= hd_lvl;
          end
          for (int s = 0; s < lfcs_pkg::QUEUE_DEPTH; s++) begin
            if (s < lfcs_pkg::QUEUE_DEPTH - 1) begin
              q_op[led][s]  <= q_op[led][s+1];
              q_lvl[led][s] <= q_lvl[led][s+1];
              q_dur[led][s] <= q_dur[led][s+1];
            end else begin
              q_op[led][s]  <= lfcs_pkg::OP_IDLE;
              q_lvl[led][s] <= 8'd0;
              q_dur[led][s] <= '0;
            end
          end
          // The following command, if any, starts at this tick's time.
          if (lfcs_pkg::QUEUE_DEPTH > 1 &&
              q_op[led][lfcs_pkg::SLOT_W'(lfcs_pkg::QUEUE_DEPTH > 1)] != lfcs_pkg::OP_IDLE) begin
            active[led]     <= 1'b1;
            start_time[led] <= now;
          end else begin
            active[led]     <= 1'b0;
            start_time[led] <= 32'd0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            res.valid        <= 1'b1;
            res.out_led      <= 3'(led);
            res.write_valid  <= res_wv;
            res.pwm_level    <= res_pwm;
            res.signal_fired <= res_sig;
            res.queue_idle   <= (hd_op == lfcs_pkg::OP_IDLE);
            res.last_result  <= at_last;
            if (at_last) begin
              state <= S_IDLE;
            end else begin
              led   <= led + 1'b1;
              state <= S_EVAL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LFCS_ASSERT_NOW(a_div_done_in_div, clk, rst, div_done, state == S_DIV)
  `LFCS_ASSERT_NOW(a_idle_no_div, clk, rst, state == S_IDLE, !div_busy)
  `LFCS_ASSERT_NEXT(a_last_ends_tick, clk, rst, state == S_EMIT && emit_go && at_last, state == S_IDLE)
endmodule

FILE: rtl/led_fade_command_sequencer_core.sv
// Top level of the LED fade command sequencer.
// The cmd channel takes one request per handshake: an enqueue of a fade,
// delay or signal command for one LED, or a tick that carries the current
// time in microseconds. An enqueue gives no result. A tick gives one result
// per LED on the res channel, in LED order, with last_result set on the
// final one.
// Requests enter a two-entry queue in the front part, so the sender can
// hand over the next request while the back part is still busy.
// An enqueue is written into its LED's queue when the back part takes it.
// On a tick, an LED that starts or holds a command goes straight to the
// emit step, one that finishes a command passes through the finish step
// first, and a fade in progress is interpolated through the multiply
// steps, a sum and the eight-step serial divider.
// When the receiver stalls, the result register holds and the LED walk
// waits; requests keep filling the front queue until it is full.
// A synchronous reset empties all command queues, clears every LED's
// active flag, start time and last level, and drops any pending result.
module led_fade_command_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  lfcs_in_if.sink    cmd,
  lfcs_out_if.source res
);
  // Classified request passed from the front queue to the back part.
  lfcs_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  lfcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // The back part owns all LED state and drives the result register.
  lfcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res        (res)
  );
endmodule
